>>> src/spi_mss_pkg.sv
package spi_mss_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SOFT_RESET_HOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_MODE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EIGHT_BIT_CHARS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_MODE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_SOURCE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BAUD_DIVIDER    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULE_ENABLE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IRQ_ENABLE      = 3'd7;

    // event codes of an input word
    localparam logic [2:0] EV_SRC_EDGE  = 3'd0;
    localparam logic [2:0] EV_CLK_PIN   = 3'd1;
    localparam logic [2:0] EV_DATA_PIN  = 3'd2;
    localparam logic [2:0] EV_WRITE_TX  = 3'd3;
    localparam logic [2:0] EV_READ_RX   = 3'd4;

    localparam logic [1:0] CLK_SRC_AUX = 2'd1;
    localparam logic       CLK_ID_AUX  = 1'b0;
    localparam logic       CLK_ID_SUB  = 1'b1;

    localparam logic [15:0] BAUD_DIV_ONE = 16'd1;

    localparam logic [7:0] CHAR_LEN_8 = 8'd8;
    localparam logic [7:0] CHAR_LEN_7 = 8'd7;
    localparam logic [7:0] RX7_MASK   = 8'h7F;

    typedef struct packed {
        logic [2:0] mode;
        logic       clock_id;
        logic       level;
        logic [7:0] tx_byte;
    } t_in_word;

    typedef struct packed {
        logic       data_out_drive;
        logic       data_out_level;
        logic       clock_out_drive;
        logic       clock_out_level;
        logic       rx_irq;
        logic       tx_irq;
        logic [7:0] read_data;
        logic       overrun_flag;
        logic       tx_empty_flag;
        logic       rx_flag;
        logic       tx_flag;
    } t_out_word;

    typedef struct packed {
        logic        soft_reset_hold;
        logic        master_mode;
        logic        eight_bit_chars;
        logic [1:0]  clock_mode;
        logic [1:0]  clock_source;
        logic [15:0] baud_divider;
        logic        module_enable;
        logic [1:0]  irq_enable;
    } t_cfg;

endpackage

>>> src/spi_master_slave_shift_engine.sv
// SPI-mode USART shift engine.
// Input channel (i_in_valid / o_in_ready / i_in_word): one event word per
// handshake - a source clock edge, a clock pin level, a data pin level, a
// transmit buffer write or a receive buffer read.
// Output channel (o_out_valid / i_out_ready / o_out_word): exactly one status
// word per event word, in order: drive strobes and levels for the serial data
// and clock lines, interrupt request pulses, receive buffer and status flags.
// The status word is registered; it appears in the cycle after its event is accepted.
// Throughput: one event word per cycle unless stalled; the whole event is
// resolved by the state update logic in the accepting cycle, the prescaler included.
// Stall: the output register holds its word while i_out_ready is low, and
// o_in_ready drops only while that register is full and not being drained,
// so a new event is taken in the same cycle that the held word leaves.
// Configuration: i_cfg_we writes register i_cfg_idx at the clock edge; write
// only while no event is in flight. Writing the baud divider reloads the
// prescaler count with the divider value.
// Reset (i_rst_n low, synchronous): shift state clears, transmit-empty sets,
// soft reset hold sets, clock source selects the auxiliary clock, divider 1.
module spi_master_slave_shift_engine (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  spi_mss_pkg::t_in_word              i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output spi_mss_pkg::t_out_word             o_out_word,
    input  logic                               i_cfg_we,
    input  logic [spi_mss_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [spi_mss_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    spi_mss_pkg::t_cfg      cfg;
    spi_mss_pkg::t_out_word result;
    spi_mss_pkg::t_out_word r_out_word;
    logic                   r_out_valid;
    logic                   div_load;
    logic                   tick;
    logic                   step;

    // take a new word whenever the output register is empty or draining
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign step        = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    spi_mss_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg),
        .o_div_load (div_load)
    );

    // divide the selected source clock into SPI clock half periods
    spi_mss_prescaler u_prescaler (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_word     (i_in_word),
        .i_cfg      (cfg),
        .i_div_load (div_load),
        .i_div_data (i_cfg_data),
        .o_tick     (tick)
    );

    // shift registers, character counter and status flags
    spi_mss_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_word   (i_in_word),
        .i_cfg    (cfg),
        .i_tick   (tick),
        .o_result (result)
    );

    // output register: load on accept, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_word <= result;
        end
    end

endmodule

>>> src/spi_mss_cfg_regs.sv
module spi_mss_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [spi_mss_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [spi_mss_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output spi_mss_pkg::t_cfg                  o_cfg,
    output logic                               o_div_load
);

    spi_mss_pkg::t_cfg r_cfg;

    assign o_cfg      = r_cfg;
    assign o_div_load = i_cfg_we && (i_cfg_idx == spi_mss_pkg::CFG_BAUD_DIVIDER);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.soft_reset_hold <= 1'b1;
            r_cfg.master_mode     <= 1'b0;
            r_cfg.eight_bit_chars <= 1'b0;
            r_cfg.clock_mode      <= 2'd0;
            r_cfg.clock_source    <= spi_mss_pkg::CLK_SRC_AUX;
            r_cfg.baud_divider    <= spi_mss_pkg::BAUD_DIV_ONE;
            r_cfg.module_enable   <= 1'b0;
            r_cfg.irq_enable      <= 2'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                spi_mss_pkg::CFG_SOFT_RESET_HOLD: r_cfg.soft_reset_hold <= i_cfg_data[0];
                spi_mss_pkg::CFG_MASTER_MODE:     r_cfg.master_mode     <= i_cfg_data[0];
                spi_mss_pkg::CFG_EIGHT_BIT_CHARS: r_cfg.eight_bit_chars <= i_cfg_data[0];
                spi_mss_pkg::CFG_CLOCK_MODE:      r_cfg.clock_mode      <= i_cfg_data[1:0];
                spi_mss_pkg::CFG_CLOCK_SOURCE:    r_cfg.clock_source    <= i_cfg_data[1:0];
                spi_mss_pkg::CFG_BAUD_DIVIDER:    r_cfg.baud_divider    <= i_cfg_data[15:0];
                spi_mss_pkg::CFG_MODULE_ENABLE:   r_cfg.module_enable   <= i_cfg_data[0];
                spi_mss_pkg::CFG_IRQ_ENABLE:      r_cfg.irq_enable      <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

endmodule

>>> src/spi_mss_prescaler.sv
module spi_mss_prescaler (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  spi_mss_pkg::t_in_word i_word,
    input  spi_mss_pkg::t_cfg     i_cfg,
    input  logic                  i_div_load,
    input  logic [15:0]           i_div_data,
    output logic                  o_tick
);

    logic [15:0] r_count;
    logic [15:0] n_count;
    logic [15:0] count_inc;
    logic        src_match;
    logic        count_en;

    // only the selected source clock counts; falling edges only at divider one
    assign src_match = ((i_cfg.clock_source == spi_mss_pkg::CLK_SRC_AUX)
                        && (i_word.clock_id == spi_mss_pkg::CLK_ID_AUX))
                    || (i_cfg.clock_source[1] && (i_word.clock_id == spi_mss_pkg::CLK_ID_SUB));
    assign count_en  = i_step && (i_word.mode == spi_mss_pkg::EV_SRC_EDGE) && src_match
                    && (i_word.level || (i_cfg.baud_divider == spi_mss_pkg::BAUD_DIV_ONE));
    assign count_inc = r_count + 16'd1;
    assign o_tick    = count_en && (count_inc >= {1'b0, i_cfg.baud_divider[15:1]});

    always_comb begin
        n_count = r_count;
        if (i_div_load) begin
            n_count = i_div_data;
        end else if (count_en) begin
            n_count = o_tick ? 16'd0 : count_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 16'd0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

>>> src/spi_mss_core.sv
module spi_mss_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  spi_mss_pkg::t_in_word  i_word,
    input  spi_mss_pkg::t_cfg      i_cfg,
    input  logic                   i_tick,
    output spi_mss_pkg::t_out_word o_result
);

    logic [7:0] r_tx_hold,  n_tx_hold;
    logic [7:0] r_tx_shift, n_tx_shift;
    logic [7:0] r_rx_shift, n_rx_shift;
    logic [7:0] r_rx_buf,   n_rx_buf;
    logic [7:0] r_bits,     n_bits;
    logic       r_phase,    n_phase;
    logic       r_busy,     n_busy;
    logic       r_pending,  n_pending;
    logic       r_rx_read,  n_rx_read;
    logic       r_din,      n_din;
    logic       r_ovr,      n_ovr;
    logic       r_txempty,  n_txempty;
    logic       r_rxflag,   n_rxflag;
    logic       r_txflag,   n_txflag;
    logic       r_dout,     n_dout;
    logic       r_sclk,     n_sclk;

    always_comb begin
        logic       edge_req;
        logic       edge_rise;
        logic       first;
        logic       ev_dout;
        logic       ev_clk;
        logic       ev_rxirq;
        logic       ev_txirq;
        logic [7:0] cap_shift;
        logic [7:0] cap_bits;
        logic [7:0] char_len;

        n_tx_hold  = r_tx_hold;
        n_tx_shift = r_tx_shift;
        n_rx_shift = r_rx_shift;
        n_rx_buf   = r_rx_buf;
        n_bits     = r_bits;
        n_phase    = r_phase;
        n_busy     = r_busy;
        n_pending  = r_pending;
        n_rx_read  = r_rx_read;
        n_din      = r_din;
        n_ovr      = r_ovr;
        n_txempty  = r_txempty;
        n_rxflag   = r_rxflag;
        n_txflag   = r_txflag;
        n_dout     = r_dout;
        n_sclk     = r_sclk;
        edge_req   = 1'b0;
        edge_rise  = 1'b0;
        first      = 1'b0;
        ev_dout    = 1'b0;
        ev_clk     = 1'b0;
        ev_rxirq   = 1'b0;
        ev_txirq   = 1'b0;
        char_len   = i_cfg.eight_bit_chars ? spi_mss_pkg::CHAR_LEN_8 : spi_mss_pkg::CHAR_LEN_7;
        cap_shift  = {r_rx_shift[6:0], r_din};
        cap_bits   = r_bits - 8'd1;

        case (i_word.mode)
            spi_mss_pkg::EV_SRC_EDGE: begin
                if (i_tick && i_cfg.master_mode && r_busy) begin
                    n_phase   = !r_phase;
                    edge_req  = 1'b1;
                    edge_rise = !r_phase;
                end
            end
            spi_mss_pkg::EV_CLK_PIN: begin
                edge_req  = 1'b1;
                edge_rise = i_word.level;
            end
            spi_mss_pkg::EV_DATA_PIN: begin
                n_din = i_word.level;
            end
            spi_mss_pkg::EV_WRITE_TX: begin
                n_tx_hold = i_word.tx_byte;
                n_txflag  = 1'b0;
                if (r_busy) begin
                    n_pending = 1'b1;
                end else if (i_cfg.module_enable) begin
                    n_tx_shift = i_word.tx_byte;
                    n_pending  = 1'b0;
                    n_busy     = 1'b1;
                    n_txempty  = 1'b0;
                    n_bits     = char_len;
                end
            end
            spi_mss_pkg::EV_READ_RX: begin
                n_ovr     = 1'b0;
                n_rxflag  = 1'b0;
                n_rx_read = 1'b1;
            end
            default: ;
        endcase

        if (edge_req && !i_cfg.soft_reset_hold) begin
            first = i_cfg.master_mode ? edge_rise : (i_cfg.clock_mode[0] == !edge_rise);
            if (first == i_cfg.clock_mode[1]) begin
                // capture one bit; latch the character after the last one
                n_rx_shift = cap_shift;
                n_bits     = cap_bits;
                if (cap_bits == 8'd0) begin
                    n_rx_buf = i_cfg.eight_bit_chars ? cap_shift
                                                     : (cap_shift & spi_mss_pkg::RX7_MASK);
                    if (!r_rx_read) begin
                        n_ovr = 1'b1;
                    end
                    n_rx_read = 1'b0;
                    if (i_cfg.irq_enable[0]) begin
                        n_rxflag = 1'b1;
                        ev_rxirq = 1'b1;
                    end
                    n_busy = 1'b0;
                    if (r_pending && i_cfg.module_enable) begin
                        n_tx_shift = r_tx_hold;
                        n_pending  = 1'b0;
                        n_busy     = 1'b1;
                        n_txempty  = 1'b0;
                        n_bits     = char_len;
                    end else begin
                        n_txempty = 1'b1;
                    end
                end
            end else begin
                // drive the next bit, MSB first
                n_dout     = i_cfg.eight_bit_chars ? r_tx_shift[7] : r_tx_shift[6];
                n_tx_shift = {r_tx_shift[6:0], 1'b0};
                ev_dout    = 1'b1;
                if ((r_bits <= 8'd1) && i_cfg.irq_enable[1]) begin
                    n_txflag = 1'b1;
                    ev_txirq = 1'b1;
                end
            end
            if (i_cfg.master_mode) begin
                n_sclk = edge_rise;
                ev_clk = 1'b1;
            end
        end

        o_result.data_out_drive  = ev_dout;
        o_result.data_out_level  = n_dout;
        o_result.clock_out_drive = ev_clk;
        o_result.clock_out_level = n_sclk ^ i_cfg.clock_mode[0];
        o_result.rx_irq          = ev_rxirq;
        o_result.tx_irq          = ev_txirq;
        o_result.read_data       = n_rx_buf;
        o_result.overrun_flag    = n_ovr;
        o_result.tx_empty_flag   = n_txempty;
        o_result.rx_flag         = n_rxflag;
        o_result.tx_flag         = n_txflag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_hold  <= 8'd0;
            r_tx_shift <= 8'd0;
            r_rx_shift <= 8'd0;
            r_rx_buf   <= 8'd0;
            r_bits     <= 8'd0;
            r_phase    <= 1'b0;
            r_busy     <= 1'b0;
            r_pending  <= 1'b0;
            r_rx_read  <= 1'b0;
            r_din      <= 1'b0;
            r_ovr      <= 1'b0;
            r_txempty  <= 1'b1;
            r_rxflag   <= 1'b0;
            r_txflag   <= 1'b0;
            r_dout     <= 1'b0;
            r_sclk     <= 1'b0;
        end else if (i_step) begin
            r_tx_hold  <= n_tx_hold;
            r_tx_shift <= n_tx_shift;
            r_rx_shift <= n_rx_shift;
            r_rx_buf   <= n_rx_buf;
            r_bits     <= n_bits;
            r_phase    <= n_phase;
            r_busy     <= n_busy;
            r_pending  <= n_pending;
            r_rx_read  <= n_rx_read;
            r_din      <= n_din;
            r_ovr      <= n_ovr;
            r_txempty  <= n_txempty;
            r_rxflag   <= n_rxflag;
            r_txflag   <= n_txflag;
            r_dout     <= n_dout;
            r_sclk     <= n_sclk;
        end
    end

endmodule
